// ===== src/orol_pkg.sv =====
// ----------------------------------------------------------------------------
// orol_pkg
// Shared sizes, codes and types of the overwriting ring with offset search.
// ----------------------------------------------------------------------------
package orol_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HANDLE_W = 32;
  localparam int LEN_W    = 16;
  localparam int OFF_W    = 20;
  localparam int SLOT_W   = 4;
  // Running byte count over all stored entries, with headroom.
  localparam int SUM_W    = LEN_W + IDX_W + 1;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_FIND = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  // Search token handed from one cell to the next.
  typedef struct packed {
    logic             tok;
    logic [SUM_W-1:0] prior;
  } tok_t;

  // Result of a request; also what a cell reports when it holds the offset.
  typedef struct packed {
    logic                hit;
    logic [IDX_W-1:0]    slot;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    pos;
  } res_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] x);
    return (x == IDX_W'(DEPTH - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] x);
    logic [SLOT_W-1:0] s;
    s = '0;
    for (int b = 0; b < IDX_W && b < SLOT_W; b++) begin
      s[b] = x[b];
    end
    return s;
  endfunction

endpackage

// ===== src/orol_cell.sv =====
// ----------------------------------------------------------------------------
// orol_cell
// One ring slot: stores an entry and checks the search token as it passes.
// ----------------------------------------------------------------------------
module orol_cell import orol_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IDX_W-1:0]    idx_i,
  input  logic                wr_en_i,
  input  logic [HANDLE_W-1:0] wr_handle_i,
  input  logic [LEN_W-1:0]    wr_len_i,
  input  logic                start_i,
  input  logic                stop_i,
  input  logic [OFF_W-1:0]    offset_i,
  input  tok_t                tok_i,
  output tok_t                tok_o,
  output res_t                hit_o,
  output logic [HANDLE_W-1:0] handle_o,
  output logic                busy_o
);

  logic [HANDLE_W-1:0] handle_q;
  logic [LEN_W-1:0]    len_q;
  logic                tok_q, tok_d;
  logic [SUM_W-1:0]    prior_q, prior_d;
  logic [SUM_W-1:0]    after;
  logic [SUM_W-1:0]    off_ext;
  logic                found;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      handle_q <= wr_handle_i;
      len_q    <= wr_len_i;
    end
  end

  always_comb begin
    if (start_i) begin
      tok_d   = 1'b1;
      prior_d = '0;
    end else begin
      tok_d   = tok_i.tok;
      prior_d = tok_i.prior;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prior_q <= prior_d;
  end

  assign after   = prior_q + SUM_W'(len_q);
  assign off_ext = SUM_W'(offset_i);
  assign found   = tok_q && (off_ext < after);

  always_comb begin
    hit_o = '0;
    if (found) begin
      hit_o.hit    = 1'b1;
      hit_o.slot   = idx_i;
      hit_o.handle = handle_q;
      hit_o.pos    = LEN_W'(off_ext - prior_q);
    end
  end

  // The token moves on only while the offset lies beyond this entry.
  assign tok_o.tok   = tok_q && !found && !stop_i;
  assign tok_o.prior = after;
  assign handle_o    = handle_q;
  assign busy_o      = tok_q;

endmodule

// ===== src/overwrite_ring_offset_locator.sv =====
// ----------------------------------------------------------------------------
// overwrite_ring_offset_locator
// Overwriting ring of entries with a search for the entry holding a byte offset.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives exactly one result item. An add
// goes from idle through the emit state into the output register. A find
// walks a token through the row of slot cells, one stored entry per cycle
// starting at the oldest, until a hit or the newest entry; on an empty ring
// it skips the walk. The next item is taken once the result has moved into
// the output register, where it may wait for the receiver while the next
// item works.
module overwrite_ring_offset_locator import orol_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [HANDLE_W-1:0] entry_handle_i,
  input  logic [LEN_W-1:0]    entry_size_i,
  input  logic [OFF_W-1:0]    char_offset_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                hit_o,
  output logic [SLOT_W-1:0]   slot_o,
  output logic [HANDLE_W-1:0] handle_out_o,
  output logic [LEN_W-1:0]    byte_in_entry_o
);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] wr_q, wr_d;
  logic [IDX_W-1:0] rd_q, rd_d;
  logic             full_q, full_d;
  logic [IDX_W-1:0] e_q, e_d;
  logic [IDX_W:0]   steps_q, steps_d;
  res_t             res_q, res_d;
  logic             out_valid_q;
  res_t             out_res_q;
  logic [OFF_W-1:0] off_q;

  logic                add_en;
  logic                start;
  logic                stop;
  logic                can_emit;
  logic                in_acc;
  res_t                hit_any;
  tok_t                tok_out [DEPTH];
  res_t                cell_hit [DEPTH];
  logic [HANDLE_W-1:0] cell_handle [DEPTH];
  logic [DEPTH-1:0]    busy;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign can_emit   = !out_valid_q || !out_stall_i;
  assign stop       = (state_q == ST_SEARCH) &&
                      ((steps_q + 1'b1 == (IDX_W + 1)'(DEPTH)) || (next_idx(e_q) == wr_q));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int Prev = (i == 0) ? DEPTH - 1 : i - 1;
    localparam logic [IDX_W-1:0] CellIdx = IDX_W'(i);

    orol_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (CellIdx),
      .wr_en_i     (add_en && (wr_q == CellIdx)),
      .wr_handle_i (entry_handle_i),
      .wr_len_i    (entry_size_i),
      .start_i     (start && (rd_q == CellIdx)),
      .stop_i      (stop),
      .offset_i    (off_q),
      .tok_i       (tok_out[Prev]),
      .tok_o       (tok_out[i]),
      .hit_o       (cell_hit[i]),
      .handle_o    (cell_handle[i]),
      .busy_o      (busy[i])
    );
  end

  // At most one cell holds the token, so the reports can be merged by OR.
  always_comb begin
    hit_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_any = res_t'(hit_any | cell_hit[IDX_W'(i)]);
    end
  end

  always_comb begin
    state_d = state_q;
    wr_d    = wr_q;
    rd_d    = rd_q;
    full_d  = full_q;
    e_d     = e_q;
    steps_d = steps_q;
    res_d   = res_q;
    add_en  = 1'b0;
    start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (req_type_i == REQ_ADD) begin
            add_en = 1'b1;
            res_d  = '0;
            if (full_q) begin
              res_d.hit    = 1'b1;
              res_d.slot   = rd_q;
              res_d.handle = cell_handle[rd_q];
              rd_d         = next_idx(rd_q);
            end
            wr_d = next_idx(wr_q);
            if (next_idx(wr_q) == rd_d) begin
              full_d = 1'b1;
            end
            state_d = ST_EMIT;
          end else if (!full_q && (rd_q == wr_q)) begin
            res_d   = '0;
            state_d = ST_EMIT;
          end else begin
            start   = 1'b1;
            e_d     = rd_q;
            steps_d = '0;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (hit_any.hit) begin
          res_d   = hit_any;
          state_d = ST_EMIT;
        end else if (stop) begin
          res_d   = '0;
          state_d = ST_EMIT;
        end else begin
          e_d     = next_idx(e_q);
          steps_d = steps_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (can_emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_q        <= '0;
      rd_q        <= '0;
      full_q      <= 1'b0;
      e_q         <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      full_q  <= full_d;
      e_q     <= e_d;
      steps_q <= steps_d;
      if (state_q == ST_EMIT && can_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_acc) begin
      off_q <= char_offset_i;
    end
    if (state_q == ST_EMIT && can_emit) begin
      out_res_q <= res_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_res_q.hit;
  assign slot_o          = slot_of(out_res_q.slot);
  assign handle_out_o    = out_res_q.handle;
  assign byte_in_entry_o = out_res_q.pos;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(busy))
    else $error("more than one cell holds the search token");

  a_token_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (busy != '0))
    else $error("search under way without a token");

  a_no_stray_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SEARCH) |-> (busy == '0))
    else $error("token left in the row outside a search");

  a_full_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (rd_q == wr_q))
    else $error("full ring with read and write indices apart");

  a_search_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (steps_q < (IDX_W + 1)'(DEPTH)))
    else $error("search walked past every slot");

endmodule

// ===== test/overwrite_ring_offset_locator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_ring_offset_locator_tb
// Self-checking bench for the overwriting ring with offset search.
// Items go in through the valid/stall port while a ring model in the bench
// predicts each result. The receiver compares every result, field by field,
// against the oldest prediction. Both sides idle at random, except for one
// long stretch.
// ----------------------------------------------------------------------------
module overwrite_ring_offset_locator_tb;
  import orol_pkg::*;

  localparam int RANDOM_ITEMS = 700;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    pos;
  } ring_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                req_type_i;
  logic [HANDLE_W-1:0] entry_handle_i;
  logic [LEN_W-1:0]    entry_size_i;
  logic [OFF_W-1:0]    char_offset_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                hit_o;
  logic [SLOT_W-1:0]   slot_o;
  logic [HANDLE_W-1:0] handle_out_o;
  logic [LEN_W-1:0]    byte_in_entry_o;

  overwrite_ring_offset_locator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .entry_handle_i  (entry_handle_i),
    .entry_size_i    (entry_size_i),
    .char_offset_i   (char_offset_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .handle_out_o    (handle_out_o),
    .byte_in_entry_o (byte_in_entry_o)
  );

  // Ring model state.
  logic [HANDLE_W-1:0] ring_handle [DEPTH];
  logic [LEN_W-1:0]    ring_len [DEPTH];
  int unsigned         ring_wr;
  int unsigned         ring_rd;
  bit                  ring_is_full;

  ring_result_t ring_results_due[$];
  int unsigned  mismatch_count;
  bit           idle_en;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial begin
    #5_000_000;
    $display("overwrite_ring_offset_locator verification failed");
    $finish;
  end

  function automatic int unsigned stored_count();
    return ring_is_full ? DEPTH : (ring_wr + DEPTH - ring_rd) % DEPTH;
  endfunction

  // Bytes held by the k oldest entries.
  function automatic int unsigned span_bytes(input int unsigned k);
    int unsigned sum;
    sum = 0;
    for (int unsigned i = 0; i < k; i++) begin
      sum += ring_len[IDX_W'((ring_rd + i) % DEPTH)];
    end
    return sum;
  endfunction

  function automatic ring_result_t predict_ring_result(input logic req,
                                                       input logic [HANDLE_W-1:0] h,
                                                       input logic [LEN_W-1:0] sz,
                                                       input logic [OFF_W-1:0] off);
    ring_result_t r;
    int unsigned  e;
    int unsigned  bytes_prior;
    int unsigned  steps;
    bit           searching;
    r = '0;
    if (req == REQ_ADD) begin
      // A full ring loses its oldest entry to the new one.
      if (ring_is_full) begin
        r.hit    = 1'b1;
        r.slot   = SLOT_W'(ring_rd);
        r.handle = ring_handle[IDX_W'(ring_rd)];
        ring_rd  = (ring_rd + 1) % DEPTH;
      end
      ring_handle[IDX_W'(ring_wr)] = h;
      ring_len[IDX_W'(ring_wr)]    = sz;
      ring_wr = (ring_wr + 1) % DEPTH;
      if (ring_wr == ring_rd) ring_is_full = 1'b1;
    end else begin
      e = ring_rd;
      bytes_prior = 0;
      steps = 0;
      searching = ring_is_full || (e != ring_wr);
      while (searching) begin
        if (off < bytes_prior + ring_len[IDX_W'(e)]) begin
          r.hit    = 1'b1;
          r.slot   = SLOT_W'(e);
          r.handle = ring_handle[IDX_W'(e)];
          r.pos    = LEN_W'(off - bytes_prior);
          searching = 1'b0;
        end else begin
          bytes_prior += ring_len[IDX_W'(e)];
          e = (e + 1) % DEPTH;
          steps++;
          searching = (e != ring_wr) && (steps < DEPTH);
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [HANDLE_W-1:0] got,
                                 input logic [HANDLE_W-1:0] want);
    if (mismatch_count < 50) begin
      $display("ERROR at %0t ns: %s is %0h, expected %0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Sends one item; entered and left at a falling edge.
  task automatic send_item(input logic req, input logic [HANDLE_W-1:0] h,
                           input logic [LEN_W-1:0] sz, input logic [OFF_W-1:0] off);
    int unsigned gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 12);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    entry_handle_i <= h;
    entry_size_i   <= sz;
    char_offset_i  <= off;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ring_results_due.push_back(predict_ring_result(req, h, sz, off));
    @(negedge clk_i);
  endtask

  task automatic store_entry(input logic [HANDLE_W-1:0] h, input logic [LEN_W-1:0] sz);
    send_item(REQ_ADD, h, sz, OFF_W'($urandom()));
  endtask

  task automatic find_offset(input logic [OFF_W-1:0] off);
    send_item(REQ_FIND, $urandom(), LEN_W'($urandom()), off);
  endtask

  task automatic test_empty_ring();
    find_offset('0);
    find_offset('1);
  endtask

  // A zero-length entry first, then the largest entry and a one-byte entry.
  task automatic test_fill_and_find();
    store_entry('0, '0);
    store_entry('1, '1);
    store_entry(32'h1234_5678, 16'd1);
    find_offset(20'd0);
    find_offset(20'd65534);
    find_offset(20'd65535);
    find_offset(20'd65536);
  endtask

  // Fill the ring with large entries, search its far end, then overwrite.
  task automatic test_overwrite();
    while (!ring_is_full) store_entry($urandom(), '1);
    find_offset(OFF_W'(span_bytes(DEPTH) - 1));
    find_offset('1);
    store_entry(32'hA5A5_0001, 16'd7);
    store_entry(32'h5A5A_0002, '0);
    find_offset(20'd0);
  endtask

  function automatic logic [HANDLE_W-1:0] pick_handle();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return $urandom();
  endfunction

  function automatic logic [LEN_W-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 30) return '1;
    if (roll < 40) return LEN_W'($urandom_range(1, 8));
    return LEN_W'($urandom());
  endfunction

  // Offsets mostly inside the stored data, often on entry boundaries,
  // sometimes just past the end, and sometimes anywhere.
  function automatic logic [OFF_W-1:0] pick_offset();
    int unsigned roll;
    int unsigned total;
    int unsigned off;
    int unsigned k;
    roll  = $urandom_range(0, 99);
    total = span_bytes(stored_count());
    if (roll < 40 && total > 0) begin
      off = $urandom_range(0, total - 1);
    end else if (roll < 60) begin
      k   = $urandom_range(0, stored_count());
      off = span_bytes(k) + $urandom_range(0, 2);
      if (off > 0) off = off - 1;
    end else if (roll < 70) begin
      off = total + $urandom_range(0, 3);
    end else begin
      off = $urandom();
    end
    if (off > (1 << OFF_W) - 1) off = (1 << OFF_W) - 1;
    return OFF_W'(off);
  endfunction

  task automatic test_random();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // One long stretch runs with neither side idling.
      idle_en = !(n >= 250 && n < 400);
      if ($urandom_range(0, 1) == 0) store_entry(pick_handle(), pick_size());
      else find_offset(pick_offset());
    end
    idle_en = 1'b1;
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= idle_en && ($urandom_range(0, 99) < 20);
    end
  end

  always @(posedge clk_i) begin : check_result
    ring_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ring_results_due.size() == 0) begin
        report_mismatch("unexpected result, handle_out", handle_out_o, '0);
      end else begin
        want = ring_results_due.pop_front();
        if (hit_o !== want.hit) begin
          report_mismatch("hit", HANDLE_W'(hit_o), HANDLE_W'(want.hit));
        end
        if (slot_o !== want.slot) begin
          report_mismatch("slot", HANDLE_W'(slot_o), HANDLE_W'(want.slot));
        end
        if (handle_out_o !== want.handle) begin
          report_mismatch("handle_out", handle_out_o, want.handle);
        end
        if (byte_in_entry_o !== want.pos) begin
          report_mismatch("byte_in_entry", HANDLE_W'(byte_in_entry_o), HANDLE_W'(want.pos));
        end
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_ADD;
    entry_handle_i = '0;
    entry_size_i   = '0;
    char_offset_i  = '0;
    idle_en        = 1'b1;
    mismatch_count = 0;
    ring_wr        = 0;
    ring_rd        = 0;
    ring_is_full   = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      ring_handle[IDX_W'(i)] = '0;
      ring_len[IDX_W'(i)]    = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_ring();
    test_fill_and_find();
    test_overwrite();
    test_random();

    in_valid_i <= 1'b0;
    while (ring_results_due.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("overwrite_ring_offset_locator verification clean");
    end else begin
      $display("overwrite_ring_offset_locator verification failed");
    end
    $finish;
  end

endmodule
